// ===== rtl/core/pk2u_pkg.sv =====
`timescale 1ns / 1ps

package pk2u_pkg;

   // Field and register widths fixed by the interface
   localparam int BYTE_W  = 8;
   localparam int LEN_W   = 11;
   localparam int INDEX_W = 10;

   // Default largest block size in bytes
   localparam int MAX_BLOCK_BYTES_DEF = 1024;

   // Register reset values
   localparam logic [LEN_W-1:0] SRC_LENGTH_RST    = LEN_W'(256);
   localparam logic [LEN_W-1:0] EXPECT_LENGTH_RST = LEN_W'(48);

   // Padding marker bytes
   localparam logic [BYTE_W-1:0] PAD_ZERO_BYTE = 8'h00;
   localparam logic [BYTE_W-1:0] PAD_TYPE2     = 8'h02;

   // Register indexes
   localparam int CSR_IDX_W = 1;
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SRC_LENGTH    = 1'b0,
      CSR_EXPECT_LENGTH = 1'b1
   } csr_idx_type;

   // One result beat
   typedef struct packed {
      logic [BYTE_W-1:0]  out_byte;
      logic [INDEX_W-1:0] out_index;
      logic               copied;
      logic               last;
   } pk2u_rsp_type;

endpackage

// ===== rtl/core/pk2u_track.sv =====
`timescale 1ns / 1ps

module pk2u_track import pk2u_pkg::*; #(
   parameter int MAX_BLOCK_BYTES = MAX_BLOCK_BYTES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [LEN_W-1:0]     csr_wr_data,
   input  logic                 accept,
   input  logic [BYTE_W-1:0]    src_byte,
   input  logic [BYTE_W-1:0]    old_dest_byte,
   output logic                 push,
   output pk2u_rsp_type         push_data
);

   // Position holds values below the clamped block length
   localparam int POS_W = (MAX_BLOCK_BYTES > 1) ? $clog2(MAX_BLOCK_BYTES) : 1;
   localparam int CW    = ((POS_W > LEN_W) ? POS_W : LEN_W) + 2;

   logic [LEN_W-1:0] src_length_ff, src_length_in;
   logic [LEN_W-1:0] expect_length_ff, expect_length_in;
   logic [POS_W-1:0] position_ff, position_in;
   logic             bad_ff, bad_in;

   logic [CW-1:0] len_w, exp_w, pos_w, p_w, data_start, sep, rel_idx;
   logic          wrap, last, len_fail, bad_cur, in_data;

   // Configuration registers
   always_comb begin
      src_length_in    = src_length_ff;
      expect_length_in = expect_length_ff;
      if (csr_wr_en) begin
         unique case (csr_idx_type'(csr_index))
            CSR_SRC_LENGTH:    src_length_in    = csr_wr_data;
            CSR_EXPECT_LENGTH: expect_length_in = csr_wr_data;
            default:           src_length_in    = src_length_ff;
         endcase
      end
   end

   // Clamp the length and locate this byte within the block
   always_comb begin
      len_w = (CW'(src_length_ff) > CW'(MAX_BLOCK_BYTES)) ? CW'(MAX_BLOCK_BYTES)
                                                        : CW'(src_length_ff);
      exp_w      = CW'(expect_length_ff);
      pos_w      = CW'(position_ff);
      wrap       = (pos_w >= len_w);
      p_w        = wrap ? '0 : pos_w;
      bad_cur    = wrap ? 1'b0 : bad_ff;
      last       = ((p_w + CW'(1)) >= len_w);
      len_fail   = (len_w < (exp_w + CW'(3)));
      data_start = len_w - exp_w;
      sep        = data_start - CW'(1);
      rel_idx    = p_w - data_start;
      in_data    = (p_w > sep);
   end

   // Check the padding and build the result beat
   always_comb begin
      bad_in              = bad_cur;
      push                = 1'b0;
      push_data.out_byte  = old_dest_byte;
      push_data.out_index = p_w[INDEX_W-1:0];
      push_data.copied    = 1'b0;
      push_data.last      = last;
      if (len_fail) begin
         push = accept;
      end else begin
         priority if (p_w == '0) begin
            if (src_byte != PAD_ZERO_BYTE) bad_in = 1'b1;
         end else if (p_w == CW'(1)) begin
            if (src_byte != PAD_TYPE2) bad_in = 1'b1;
         end else if (p_w < sep) begin
            if (src_byte == PAD_ZERO_BYTE) bad_in = 1'b1;
         end else if (!in_data) begin
            if (src_byte != PAD_ZERO_BYTE) bad_in = 1'b1;
         end else begin
            push                = accept;
            push_data.out_index = rel_idx[INDEX_W-1:0];
            push_data.copied    = !bad_cur;
            push_data.out_byte  = bad_cur ? old_dest_byte : src_byte;
         end
      end
      if (last) begin
         bad_in = 1'b0;
      end
      position_in = last ? '0 : POS_W'(p_w + CW'(1));
   end

   // Hold configuration and advance block state on each accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         src_length_ff    <= SRC_LENGTH_RST;
         expect_length_ff <= EXPECT_LENGTH_RST;
         position_ff      <= '0;
         bad_ff           <= 1'b0;
      end else begin
         src_length_ff    <= src_length_in;
         expect_length_ff <= expect_length_in;
         if (accept) begin
            position_ff <= position_in;
            bad_ff      <= bad_in;
         end
      end
   end

endmodule

// ===== rtl/core/pk2u_skid.sv =====
`timescale 1ns / 1ps

module pk2u_skid import pk2u_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  pk2u_rsp_type push_data,
   output logic         in_ready,
   output logic         out_valid,
   input  logic         out_ready,
   output pk2u_rsp_type out_data
);

   logic         main_valid_ff, main_valid_in;
   logic         spare_valid_ff, spare_valid_in;
   pk2u_rsp_type main_ff, main_in;
   pk2u_rsp_type spare_ff, spare_in;
   logic         drain;

   assign drain     = main_valid_ff && out_ready;
   assign in_ready  = !spare_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   // Move the spare beat forward, else load or hold the new beat
   always_comb begin
      main_valid_in  = main_valid_ff;
      spare_valid_in = spare_valid_ff;
      main_in        = main_ff;
      spare_in       = spare_ff;
      if (spare_valid_ff) begin
         if (drain) begin
            main_in        = spare_ff;
            spare_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || drain) begin
            main_in       = push_data;
            main_valid_in = 1'b1;
         end else begin
            spare_in       = push_data;
            spare_valid_in = 1'b1;
         end
      end else if (drain) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff  <= 1'b0;
         spare_valid_ff <= 1'b0;
      end else begin
         main_valid_ff  <= main_valid_in;
         spare_valid_ff <= spare_valid_in;
      end
      main_ff  <= main_in;
      spare_ff <= spare_in;
   end

endmodule

// ===== rtl/core/pkcs1_type2_unpad_stream.sv =====
`timescale 1ns / 1ps

// Streaming PKCS#1 v1.5 type 2 unpadding. One beat on req_ carries the next byte of a
// decrypted block together with the old destination byte; the block checks the 00 02
// header, the nonzero padding and the zero separator on the fly, and for each of the
// last expect_length bytes returns one rsp_ beat holding the source byte (copied = 1)
// or, on bad padding, the old byte. Header and padding beats give no result. When the
// clamped src_length < expect_length + 3 every beat returns the old byte as is. A new
// beat is taken every cycle: the check is one registered pass from the position/flag
// registers into a two-entry output buffer, so req_ready drops only when both entries
// hold results that rsp_ready has not taken. Write csr_ registers only while idle.
module pkcs1_type2_unpad_stream import pk2u_pkg::*; #(
   parameter int MAX_BLOCK_BYTES = MAX_BLOCK_BYTES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [LEN_W-1:0]     csr_wr_data,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [BYTE_W-1:0]    req_src_byte,
   input  logic [BYTE_W-1:0]    req_old_dest_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [BYTE_W-1:0]    rsp_out_byte,
   output logic [INDEX_W-1:0]   rsp_out_index,
   output logic                 rsp_copied,
   output logic                 rsp_last
);

   logic         accept;
   logic         push;
   pk2u_rsp_type push_data;
   pk2u_rsp_type rsp_data;

   assign accept = req_valid && req_ready;

   pk2u_track #(
      .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES)
   ) u_track (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wr_data   (csr_wr_data),
      .accept        (accept),
      .src_byte      (req_src_byte),
      .old_dest_byte (req_old_dest_byte),
      .push          (push),
      .push_data     (push_data)
   );

   pk2u_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .in_ready  (req_ready),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   assign rsp_out_byte  = rsp_data.out_byte;
   assign rsp_out_index = rsp_data.out_index;
   assign rsp_copied    = rsp_data.copied;
   assign rsp_last      = rsp_data.last;

endmodule

// ===== rtl/core/pk2u_checker.sv =====
`timescale 1ns / 1ps

module pk2u_checker import pk2u_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic [BYTE_W-1:0]    req_src_byte,
   input logic [BYTE_W-1:0]    req_old_dest_byte,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [BYTE_W-1:0]    rsp_out_byte,
   input logic [INDEX_W-1:0]   rsp_out_index,
   input logic                 rsp_copied,
   input logic                 rsp_last
);

   // Nothing is pending right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat shown right after reset");

   // A stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_out_index) && $stable(rsp_copied) && $stable(rsp_last))
      else $error("stalled result beat changed or dropped");

   // Backpressure only while a result waits
   a_ready_needs_rsp: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("req_ready low with no result pending");

   // The buffer fills only from a beat taken while the output stalled
   a_ready_fall: assert property (@(posedge clock) disable iff (reset)
      $fell(req_ready) |-> $past(req_valid && !rsp_ready))
      else $error("req_ready fell without a stalled accept");

   // A waiting request beat holds its payload
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_src_byte)
         && $stable(req_old_dest_byte))
      else $error("stalled request beat changed or dropped");

endmodule

bind pkcs1_type2_unpad_stream pk2u_checker u_pk2u_checker (.*);

// ===== sim/pkcs1_type2_unpad_stream_tb.sv =====
`timescale 1ns / 1ps

module pkcs1_type2_unpad_stream_tb;
   import pk2u_pkg::*;

   localparam int MAX_BYTES    = MAX_BLOCK_BYTES_DEF;
   localparam int SETTLE       = 8;
   localparam int LIMIT        = 200000;
   localparam int RANDOM_BEATS = 724;

   typedef enum int {ROW_CFG, ROW_BEAT, ROW_TYPED} row_kind_type;
   typedef enum int {BLK_GOOD, BLK_FAULT, BLK_NOISE} block_kind_type;

   typedef struct {
      row_kind_type     kind;
      int unsigned      src_len;
      int unsigned      pay_len;
      logic [BYTE_W-1:0] src_byte;
      logic [BYTE_W-1:0] old_byte;
      bit               has_rsp;
      pk2u_rsp_type     rsp;
   } stim_row_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [LEN_W-1:0]     csr_wr_data;
   logic                 req_valid;
   logic                 req_ready;
   logic [BYTE_W-1:0]    req_src_byte;
   logic [BYTE_W-1:0]    req_old_dest_byte;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [BYTE_W-1:0]    rsp_out_byte;
   logic [INDEX_W-1:0]   rsp_out_index;
   logic                 rsp_copied;
   logic                 rsp_last;

   // Results still owed by the block, oldest first
   pk2u_rsp_type expected_q[$];
   stim_row_type stim_rows[$];

   // Unpadding state mirrored from the block
   logic [LEN_W-1:0] cfg_src_len;
   logic [LEN_W-1:0] cfg_pay_len;
   int unsigned      blk_pos;
   bit               blk_bad;

   // Shape of the block being generated
   block_kind_type blk_kind;
   int unsigned    fault_pos;

   int errors;
   int cycles;
   int beats_sent;
   int send_idle_pct;
   int recv_idle_pct;

   pkcs1_type2_unpad_stream #(
      .MAX_BLOCK_BYTES(MAX_BYTES)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_src_byte     (req_src_byte),
      .req_old_dest_byte(req_old_dest_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_out_index    (rsp_out_index),
      .rsp_copied       (rsp_copied),
      .rsp_last         (rsp_last)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Block length as the hardware sees it: clamp oversized values
   function automatic int unsigned block_len();
      return (cfg_src_len > MAX_BYTES) ? MAX_BYTES : int'(cfg_src_len);
   endfunction

   // Advance the unpadding state by one source byte; report the result it yields
   function automatic void unpad_predict(input logic [BYTE_W-1:0] sb,
                                         input logic [BYTE_W-1:0] ob,
                                         output bit has, output pk2u_rsp_type r);
      int unsigned len;
      int unsigned pay_len;
      int unsigned p;
      int unsigned data_start;
      bit lst;
      bit take;
      len     = block_len();
      pay_len = cfg_pay_len;
      has     = 1'b0;
      r       = '0;
      if (blk_pos >= len) begin
         blk_pos = 0;
         blk_bad = 1'b0;
      end
      p   = blk_pos;
      lst = (p + 1 >= len);
      if (len < pay_len + 3) begin
         // Length check failed: pass every old byte through
         has         = 1'b1;
         r.out_byte  = ob;
         r.out_index = INDEX_W'(p);
         r.copied    = 1'b0;
         r.last      = lst;
      end else begin
         data_start = len - pay_len;
         if (p == 0) begin
            if (sb != PAD_ZERO_BYTE) blk_bad = 1'b1;
         end else if (p == 1) begin
            if (sb != PAD_TYPE2) blk_bad = 1'b1;
         end else if (p < data_start - 1) begin
            if (sb == PAD_ZERO_BYTE) blk_bad = 1'b1;
         end else if (p == data_start - 1) begin
            if (sb != PAD_ZERO_BYTE) blk_bad = 1'b1;
         end else begin
            take        = !blk_bad;
            has         = 1'b1;
            r.out_byte  = take ? sb : ob;
            r.out_index = INDEX_W'(p - data_start);
            r.copied    = take;
            r.last      = lst;
         end
      end
      if (lst) begin
         blk_pos = 0;
         blk_bad = 1'b0;
      end else begin
         blk_pos = p + 1;
      end
   endfunction

   // Choose the next source byte: mostly well-formed blocks, some with one fault, some noise
   function automatic logic [BYTE_W-1:0] pick_src_byte();
      int unsigned len;
      int unsigned p;
      int unsigned sep;
      int unsigned roll;
      logic [BYTE_W-1:0] v;
      len = block_len();
      p   = (blk_pos >= len) ? 0 : blk_pos;
      if (len < cfg_pay_len + 3) return BYTE_W'($urandom_range(0, 255));
      sep = len - cfg_pay_len - 1;
      if (p == 0) begin
         roll      = $urandom_range(0, 99);
         blk_kind  = (roll < 75) ? BLK_GOOD : (roll < 88) ? BLK_FAULT : BLK_NOISE;
         fault_pos = $urandom_range(0, sep);
      end
      if (blk_kind == BLK_NOISE) return BYTE_W'($urandom_range(0, 255));
      if (blk_kind == BLK_FAULT && p == fault_pos) begin
         // Break exactly one header, padding or separator byte
         if (p == 0) return BYTE_W'($urandom_range(1, 255));
         if (p == 1) begin
            v = BYTE_W'($urandom_range(0, 254));
            return (v >= PAD_TYPE2) ? v + 1'b1 : v;
         end
         if (p < sep) return PAD_ZERO_BYTE;
         return BYTE_W'($urandom_range(1, 255));
      end
      if (p == 0) return PAD_ZERO_BYTE;
      if (p == 1) return PAD_TYPE2;
      if (p < sep) return BYTE_W'($urandom_range(1, 255));
      if (p == sep) return PAD_ZERO_BYTE;
      return BYTE_W'($urandom_range(0, 255));
   endfunction

   function automatic void add_cfg(input int unsigned src_len, input int unsigned pay_len);
      stim_row_type row;
      row         = '{kind: ROW_CFG, default: '0};
      row.src_len = src_len;
      row.pay_len = pay_len;
      stim_rows.push_back(row);
   endfunction

   function automatic void add_beat(input logic [BYTE_W-1:0] sb, input logic [BYTE_W-1:0] ob);
      stim_row_type row;
      row          = '{kind: ROW_BEAT, default: '0};
      row.src_byte = sb;
      row.old_byte = ob;
      stim_rows.push_back(row);
   endfunction

   // Beat whose outcome is written out by hand; has = 0 means no result
   function automatic void add_typed(input logic [BYTE_W-1:0] sb, input logic [BYTE_W-1:0] ob,
                                     input bit has, input logic [BYTE_W-1:0] eb,
                                     input int unsigned ei, input bit ec, input bit el);
      stim_row_type row;
      row               = '{kind: ROW_TYPED, default: '0};
      row.src_byte      = sb;
      row.old_byte      = ob;
      row.has_rsp       = has;
      row.rsp.out_byte  = eb;
      row.rsp.out_index = INDEX_W'(ei);
      row.rsp.copied    = ec;
      row.rsp.last      = el;
      stim_rows.push_back(row);
   endfunction

   // Write both length registers once the block has nothing left in flight
   task automatic set_config(input int unsigned src_len, input int unsigned pay_len);
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_SRC_LENGTH;
      csr_wr_data <= LEN_W'(src_len);
      @(posedge clock);
      cfg_src_len = LEN_W'(src_len);
      csr_index   <= CSR_EXPECT_LENGTH;
      csr_wr_data <= LEN_W'(pay_len);
      @(posedge clock);
      cfg_pay_len = LEN_W'(pay_len);
      csr_wr_en <= 1'b0;
   endtask

   // Hold the sender off until every owed result has come back
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_q.size() != 0) @(posedge clock);
   endtask

   // Drive one beat, wait for the handshake, then record what it should produce
   task automatic send_beat(input logic [BYTE_W-1:0] sb, input logic [BYTE_W-1:0] ob,
                            input bit typed, input bit typed_has,
                            input pk2u_rsp_type typed_rsp);
      bit has;
      pk2u_rsp_type r;
      if (beats_sent < 260) begin
         send_idle_pct = 18;
         recv_idle_pct = 57;
      end else if (beats_sent < 520) begin
         send_idle_pct = 57;
         recv_idle_pct = 18;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_src_byte      <= sb;
      req_old_dest_byte <= ob;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      unpad_predict(sb, ob, has, r);
      if (typed) begin
         has = typed_has;
         r   = typed_rsp;
      end
      if (has) expected_q.push_back(r);
      beats_sent++;
   endtask

   function automatic void compare_field(input string name, input int unsigned want,
                                         input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         errors++;
      end
   endfunction

   task automatic check_result();
      pk2u_rsp_type want;
      if (expected_q.size() == 0) begin
         $display("%0t: unexpected result, expected none, %s %0h index %0d copied %0b last %0b",
                  $time, "actual byte", rsp_out_byte, rsp_out_index, rsp_copied, rsp_last);
         errors++;
      end else begin
         want = expected_q.pop_front();
         compare_field("out_byte", want.out_byte, rsp_out_byte);
         compare_field("out_index", want.out_index, rsp_out_index);
         compare_field("copied", want.copied, rsp_copied);
         compare_field("last", want.last, rsp_last);
      end
   endtask

   // Receiver: stall at random and check every result beat taken
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
      if (!reset && rsp_valid && rsp_ready) check_result();
   end

   // Watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      int unsigned src_len;
      int unsigned pay_len;
      int unsigned len;
      int unsigned beats;
      int unsigned roll;
      int ph;
      int dir_beats;

      reset             = 1'b1;
      csr_wr_en         = 1'b0;
      csr_index         = CSR_SRC_LENGTH;
      csr_wr_data       = '0;
      req_valid         = 1'b0;
      req_src_byte      = '0;
      req_old_dest_byte = '0;
      cfg_src_len       = SRC_LENGTH_RST;
      cfg_pay_len       = EXPECT_LENGTH_RST;
      blk_pos           = 0;
      blk_bad           = 1'b0;
      blk_kind          = BLK_GOOD;
      fault_pos         = 0;
      beats_sent        = 0;
      send_idle_pct     = 18;
      recv_idle_pct     = 57;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Five-byte blocks with one payload byte: header, one pad byte, separator, data
      add_cfg(5, 1);
      // well-formed block: payload copied
      add_typed(8'h00, 8'h11, 0, 8'h00, 0, 0, 0);
      add_typed(8'h02, 8'h22, 0, 8'h00, 0, 0, 0);
      add_typed(8'hFF, 8'h33, 0, 8'h00, 0, 0, 0);
      add_typed(8'h00, 8'h44, 0, 8'h00, 0, 0, 0);
      add_typed(8'h80, 8'hD5, 1, 8'h80, 0, 1, 1);
      // first byte not zero: old byte kept
      add_typed(8'h01, 8'h00, 0, 8'h00, 0, 0, 0);
      add_typed(8'h02, 8'h01, 0, 8'h00, 0, 0, 0);
      add_typed(8'h01, 8'h02, 0, 8'h00, 0, 0, 0);
      add_typed(8'h00, 8'h03, 0, 8'h00, 0, 0, 0);
      add_typed(8'h7F, 8'hD6, 1, 8'hD6, 0, 0, 1);
      // wrong block type byte
      add_typed(8'h00, 8'hFF, 0, 8'h00, 0, 0, 0);
      add_typed(8'h03, 8'hFF, 0, 8'h00, 0, 0, 0);
      add_typed(8'h55, 8'hFF, 0, 8'h00, 0, 0, 0);
      add_typed(8'h00, 8'hFF, 0, 8'h00, 0, 0, 0);
      add_typed(8'hFF, 8'h00, 1, 8'h00, 0, 0, 1);
      // zero byte inside the padding
      add_beat(8'h00, 8'h9A);
      add_beat(8'h02, 8'h9B);
      add_beat(8'h00, 8'h9C);
      add_beat(8'h00, 8'h9D);
      add_beat(8'h00, 8'hFF);
      // nonzero separator
      add_beat(8'h00, 8'hA0);
      add_beat(8'h02, 8'hA1);
      add_beat(8'hFE, 8'hA2);
      add_beat(8'h01, 8'hA3);
      add_beat(8'h40, 8'hBF);
      // block too short for header and separator: old byte passes through
      add_cfg(1, 0);
      add_typed(8'hC3, 8'h3C, 1, 8'h3C, 0, 0, 1);

      foreach (stim_rows[i]) begin
         case (stim_rows[i].kind)
            ROW_CFG: begin
               set_config(stim_rows[i].src_len, stim_rows[i].pay_len);
            end
            ROW_BEAT: begin
               send_beat(stim_rows[i].src_byte, stim_rows[i].old_byte, 0, 0, '0);
            end
            default: begin
               send_beat(stim_rows[i].src_byte, stim_rows[i].old_byte, 1,
                         stim_rows[i].has_rsp, stim_rows[i].rsp);
            end
         endcase
      end
      dir_beats = beats_sent;

      // Random phases: extreme settings first, partial blocks leave reconfig mid-block
      ph = 0;
      while (beats_sent < dir_beats + RANDOM_BEATS) begin
         case (ph)
            0: begin src_len = 2047; pay_len = 1000; beats = 70; end
            1: begin src_len = 1024; pay_len = 1021; beats = 40; end
            2: begin src_len = 1024; pay_len = 1022; beats = 24; end
            3: begin src_len = 2047; pay_len = 2047; beats = 8;  end
            4: begin src_len = 0;    pay_len = 0;    beats = 4;  end
            5: begin src_len = 3;    pay_len = 0;    beats = 9;  end
            6: begin src_len = 0;    pay_len = 2047; beats = 3;  end
            default: begin
               roll = $urandom_range(0, 9);
               if (roll < 7) begin
                  src_len = $urandom_range(3, 40);
                  pay_len = $urandom_range(0, src_len - 3);
               end else if (roll < 9) begin
                  pay_len = $urandom_range(0, 15);
                  src_len = $urandom_range(0, pay_len + 2);
               end else begin
                  src_len = $urandom_range(41, 300);
                  pay_len = $urandom_range(0, src_len - 3);
               end
               len   = (src_len == 0) ? 1 : src_len;
               beats = len * $urandom_range(1, 4);
               if ($urandom_range(0, 2) == 0) beats += $urandom_range(1, len);
               if (beats > 400) beats = 400;
            end
         endcase
         // Stop the last phase at the planned beat count
         if (int'(beats) > dir_beats + RANDOM_BEATS - beats_sent)
            beats = dir_beats + RANDOM_BEATS - beats_sent;
         set_config(src_len, pay_len);
         for (int unsigned k = 0; k < beats; k++) begin
            if ((ph == 7 && k == beats / 2) || $urandom_range(0, 149) == 0)
               hold_until_drained();
            send_beat(pick_src_byte(), BYTE_W'($urandom_range(0, 255)), 0, 0, '0);
         end
         ph++;
      end

      // Drain the remaining results, then give the pipeline time to show strays
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
